FILE: rtl/core/rrs_pkg.sv
package rrs_pkg;

	localparam int NPROC      = 8;
	localparam int NTHR       = 8;
	localparam int PIDX_W     = 3;
	localparam int TIDX_W     = 3;
	localparam int SLOT_W     = PIDX_W + TIDX_W;
	localparam int NSLOTS     = NPROC * NTHR;
	localparam int CNT_W      = 4;
	localparam int DUR_W      = 24;
	localparam int DIR_W      = 32;
	localparam int PER_W      = 16;
	localparam logic [PER_W-1:0] PERIOD_RESET = 16'd50;

	localparam logic [1:0] MODE_TICK   = 2'd0;
	localparam logic [1:0] MODE_NEWPROC = 2'd1;
	localparam logic [1:0] MODE_NEWTHR = 2'd2;
	localparam logic [1:0] MODE_SLEEP  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_NORDY = 2'd2;
	localparam logic [1:0] ST_BADIX = 2'd3;

	typedef struct packed {
		logic [1:0]        mode;
		logic [PIDX_W-1:0] process_index;
		logic [TIDX_W-1:0] thread_index;
		logic [DUR_W-1:0]  duration;
		logic [DIR_W-1:0]  directory_base;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic              switched;
		logic [PIDX_W-1:0] sel_process;
		logic [TIDX_W-1:0] sel_thread;
		logic [DIR_W-1:0]  directory_out;
	} res_t;

endpackage

FILE: rtl/core/rrs_ram.sv
module rrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rd_q;
	logic             rv_q;

	// entries read as zero until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rv_q  <= 1'b0;
		end else begin
			rv_q <= vld_q[raddr];
			if (we) vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	assign rdata = rv_q ? rd_q : '0;

endmodule

FILE: rtl/core/rrs_seq.sv
module rrs_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [15:0]         cfg_wr_data,
	input  logic                start,
	input  rrs_pkg::req_t       req,
	output logic                idle,
	output logic                res_valid,
	input  logic                res_take,
	output rrs_pkg::res_t       res
);
	import rrs_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_V0   = 4'd1;
	localparam logic [3:0] S_V1   = 4'd2;
	localparam logic [3:0] S_V2   = 4'd3;
	localparam logic [3:0] S_V3   = 4'd4;
	localparam logic [3:0] S_SWP  = 4'd5;
	localparam logic [3:0] S_DIV  = 4'd6;
	localparam logic [3:0] S_SRD  = 4'd7;
	localparam logic [3:0] S_SWR  = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	logic [3:0]        state_q;
	logic [PER_W-1:0]  per_q;
	logic [PIDX_W-1:0] ph_q;
	logic [CNT_W-1:0]  pc_q;
	logic [PIDX_W-1:0] pring_q [NPROC];
	logic [DIR_W-1:0]  root_q [NPROC];
	logic [TIDX_W-1:0] th_q [NPROC];
	logic [CNT_W-1:0]  tc_q [NPROC];
	logic [SLOT_W-1:0] cur_q;
	logic [5:0]        visit_q;
	logic [6:0]        idx_q;
	logic [PIDX_W-1:0] p_q;
	logic [TIDX_W-1:0] t_q;
	logic [PIDX_W-1:0] pi_q;
	logic [TIDX_W-1:0] ti_q;
	logic [DUR_W-1:0]  dur_q;
	logic [DUR_W-1:0]  sh_q;
	logic [DUR_W-1:0]  d_q;
	logic [PER_W-1:0]  rem_q;
	logic [4:0]        cnt_q;
	res_t              res_q;

	logic              tr_we, sl_we;
	logic [SLOT_W-1:0] tr_waddr, tr_raddr, sl_waddr, sl_raddr;
	logic [TIDX_W-1:0] tr_wdata, tr_rdata;
	logic [DUR_W-1:0]  sl_wdata, sl_rdata;

	logic [PIDX_W-1:0] p0;
	logic              np_ok, nt_bad, nt_full, sl_bad;
	logic [PER_W:0]    r2, r2s;
	logic [DUR_W-1:0]  dec;

	assign p0      = (pc_q > 4'd1) ? pring_q[ph_q + 3'd1] : pring_q[ph_q];
	assign np_ok   = !pc_q[3];
	assign nt_bad  = {1'b0, req.process_index} >= pc_q;
	assign nt_full = tc_q[req.process_index][3];
	assign sl_bad  = nt_bad || ({1'b0, req.thread_index} >= tc_q[req.process_index]);
	assign r2      = {rem_q, sh_q[DUR_W-1]};
	assign r2s     = (r2 >= {1'b0, per_q}) ? r2 - {1'b0, per_q} : r2;
	assign dec     = (sl_rdata > {8'd0, per_q}) ? sl_rdata - {8'd0, per_q} : '0;

	always_comb begin
		tr_we = 1'b0; tr_waddr = '0; tr_wdata = '0; tr_raddr = '0;
		sl_we = 1'b0; sl_waddr = '0; sl_wdata = '0; sl_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start && req.mode == MODE_NEWPROC && np_ok) begin
					tr_we = 1'b1; tr_waddr = {pc_q[2:0], 3'd0};
					sl_we = 1'b1; sl_waddr = {pc_q[2:0], 3'd0};
				end else if (start && req.mode == MODE_NEWTHR && !nt_bad && !nt_full) begin
					tr_we    = 1'b1;
					tr_waddr = {req.process_index,
						th_q[req.process_index] + tc_q[req.process_index][2:0]};
					tr_wdata = tc_q[req.process_index][2:0];
					sl_we    = 1'b1;
					sl_waddr = {req.process_index, tc_q[req.process_index][2:0]};
				end
			end
			S_V0: tr_raddr = {p0, th_q[p0]};
			S_V1: begin
				if (tc_q[p_q] > 4'd1) begin
					tr_we    = 1'b1;
					tr_waddr = {p_q, th_q[p_q] + tc_q[p_q][2:0]};
					tr_wdata = tr_rdata;
					tr_raddr = {p_q, th_q[p_q] + 3'd1};
				end else begin
					sl_raddr = {p_q, tr_rdata};
				end
			end
			S_V2: sl_raddr = {p_q, tr_rdata};
			S_SWP: begin
				sl_raddr = idx_q[5:0];
				if (idx_q != 7'd0) begin
					sl_we    = 1'b1;
					sl_waddr = idx_q[5:0] - 6'd1;
					sl_wdata = dec;
				end
			end
			S_SRD: sl_raddr = {pi_q, ti_q};
			S_SWR: begin
				if (sl_rdata < d_q) begin
					sl_we = 1'b1; sl_waddr = {pi_q, ti_q}; sl_wdata = d_q;
				end
			end
			default: ;
		endcase
	end

	rrs_ram #(.WIDTH(TIDX_W), .DEPTH(NSLOTS)) u_tr (
		.clk(clk), .arst_n(arst_n), .we(tr_we), .waddr(tr_waddr),
		.wdata(tr_wdata), .raddr(tr_raddr), .rdata(tr_rdata)
	);

	rrs_ram #(.WIDTH(DUR_W), .DEPTH(NSLOTS)) u_sl (
		.clk(clk), .arst_n(arst_n), .we(sl_we), .waddr(sl_waddr),
		.wdata(sl_wdata), .raddr(sl_raddr), .rdata(sl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			per_q   <= PERIOD_RESET;
			ph_q    <= '0;
			pc_q    <= 4'd1;
			cur_q   <= '0;
			visit_q <= '0;
			idx_q   <= '0;
			cnt_q   <= '0;
			for (int i = 0; i < NPROC; i++) begin
				pring_q[i] <= '0;
				root_q[i]  <= '0;
				th_q[i]    <= '0;
				tc_q[i]    <= (i == 0) ? 4'd1 : 4'd0;
			end
		end else begin
			if (cfg_wr_en) per_q <= cfg_wr_data;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						pi_q  <= req.process_index;
						ti_q  <= req.thread_index;
						dur_q <= req.duration;
						unique case (req.mode)
							MODE_TICK: begin
								res_q   <= '0;
								visit_q <= '0;
								state_q <= S_V0;
							end
							MODE_NEWPROC: begin
								if (!np_ok) begin
									res_q <= {ST_FULL, 1'b0, 3'd0, 3'd0, {DIR_W{1'b0}}};
								end else begin
									root_q[pc_q[2:0]]         <= req.directory_base;
									pring_q[ph_q + pc_q[2:0]] <= pc_q[2:0];
									th_q[pc_q[2:0]]           <= '0;
									tc_q[pc_q[2:0]]           <= 4'd1;
									pc_q                      <= pc_q + 4'd1;
									res_q <= {ST_OK, 1'b0, pc_q[2:0], 3'd0, {DIR_W{1'b0}}};
								end
								state_q <= S_DONE;
							end
							MODE_NEWTHR: begin
								if (nt_bad) begin
									res_q <= {ST_BADIX, 1'b0, 3'd0, 3'd0, {DIR_W{1'b0}}};
								end else if (nt_full) begin
									res_q <= {ST_FULL, 1'b0, 3'd0, 3'd0, {DIR_W{1'b0}}};
								end else begin
									tc_q[req.process_index] <= tc_q[req.process_index] + 4'd1;
									res_q <= {ST_OK, 1'b0, req.process_index,
										tc_q[req.process_index][2:0], {DIR_W{1'b0}}};
								end
								state_q <= S_DONE;
							end
							MODE_SLEEP: begin
								if (sl_bad) begin
									res_q   <= {ST_BADIX, 1'b0, 3'd0, 3'd0, {DIR_W{1'b0}}};
									state_q <= S_DONE;
								end else if (per_q == '0) begin
									res_q   <= '0;
									d_q     <= req.duration;
									state_q <= S_SRD;
								end else begin
									res_q   <= '0;
									rem_q   <= '0;
									sh_q    <= req.duration;
									cnt_q   <= '0;
									state_q <= S_DIV;
								end
							end
							default: res_q <= '0;
						endcase
					end
				end
				S_V0: begin
					if (pc_q > 4'd1) begin
						pring_q[ph_q + pc_q[2:0]] <= pring_q[ph_q];
						ph_q <= ph_q + 3'd1;
					end
					p_q <= p0;
					if (tc_q[p0] == '0) begin
						if (visit_q == 6'd63) begin
							res_q.status <= ST_NORDY;
							idx_q        <= '0;
							state_q      <= S_SWP;
						end else begin
							visit_q <= visit_q + 6'd1;
						end
					end else begin
						state_q <= S_V1;
					end
				end
				S_V1: begin
					if (tc_q[p_q] > 4'd1) begin
						th_q[p_q] <= th_q[p_q] + 3'd1;
						state_q   <= S_V2;
					end else begin
						t_q     <= tr_rdata;
						state_q <= S_V3;
					end
				end
				S_V2: begin
					t_q     <= tr_rdata;
					state_q <= S_V3;
				end
				S_V3: begin
					if (sl_rdata == '0) begin
						cur_q          <= {p_q, t_q};
						res_q.switched <= ({p_q, t_q} != cur_q);
						idx_q          <= '0;
						state_q        <= S_SWP;
					end else if (visit_q == 6'd63) begin
						res_q.status <= ST_NORDY;
						idx_q        <= '0;
						state_q      <= S_SWP;
					end else begin
						visit_q <= visit_q + 6'd1;
						state_q <= S_V0;
					end
				end
				S_SWP: begin
					if (idx_q == 7'(NSLOTS)) begin
						res_q   <= {res_q.status, res_q.switched,
							cur_q[SLOT_W-1:TIDX_W], cur_q[TIDX_W-1:0],
							root_q[cur_q[SLOT_W-1:TIDX_W]]};
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + 7'd1;
					end
				end
				S_DIV: begin
					rem_q <= r2s[PER_W-1:0];
					sh_q  <= {sh_q[DUR_W-2:0], 1'b0};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(DUR_W - 1)) begin
						d_q     <= dur_q - {8'd0, r2s[PER_W-1:0]};
						state_q <= S_SRD;
					end
				end
				S_SRD: state_q <= S_SWR;
				S_SWR: state_q <= S_DONE;
				S_DONE: if (res_take) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q >= 4'd1 && pc_q <= 4'(NPROC))
		else $error("process count out of range");
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_take |=> res_valid && $stable(res_q))
		else $error("result dropped before transfer");
	a_sweep_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SWP |-> idx_q <= 7'(NSLOTS))
		else $error("sweep index overrun");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> idle)
		else $error("start while busy");

endmodule

FILE: rtl/core/two_level_round_robin_sleep_scheduler.sv
// Two-level round-robin thread scheduler with per-thread sleep timers. Items
// are handled one at a time. A tick (mode 0) visits processes in ring order
// (state V0 alone for a process without threads, V0, V1 and V3 for a process
// with a single thread, V0 through V3 otherwise), stopping at the first
// thread whose sleep counter is zero or after 64 visits, then sweeps all 64
// sleep counters through the sleep memory. Create process and create thread
// go straight to the result. Sleep runs the one-bit-a-cycle remainder unit
// that rounds the duration down to whole periods (skipped when the period
// is zero). With no ready thread the tick reports status 2 and keeps the
// current thread. A new item is taken as soon as the previous result sits in
// the output register. switch_period_ms is to be written through
// cfg_wr_en/cfg_wr_data only while idle; the block does not enforce this.
module two_level_round_robin_sleep_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [2:0]  process_index,
	input  logic [2:0]  thread_index,
	input  logic [23:0] duration,
	input  logic [31:0] directory_base,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        switched,
	output logic [2:0]  sel_process,
	output logic [2:0]  sel_thread,
	output logic [31:0] directory_out
);
	import rrs_pkg::*;

	req_t req;
	res_t res, out_q;
	logic idle, res_valid, res_take, out_valid_q;

	// gather the input fields for the sequencer
	assign req = '{mode: mode, process_index: process_index,
		thread_index: thread_index, duration: duration,
		directory_base: directory_base};

	// input transfer only while the sequencer is free
	assign in_ready = idle;

	rrs_seq u_seq (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.start(in_valid && idle), .req(req),
		.idle(idle), .res_valid(res_valid), .res_take(res_take), .res(res)
	);

	// result register parts the sequencer from the output side
	assign res_take = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) out_q <= res;
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign switched      = out_q.switched;
	assign sel_process   = out_q.sel_process;
	assign sel_thread    = out_q.sel_thread;
	assign directory_out = out_q.directory_out;

endmodule

FILE: tb/tb_two_level_round_robin_sleep_scheduler.sv
module tb_two_level_round_robin_sleep_scheduler;
	import rrs_pkg::*;

	// run length guard: room for the longest ticks, stalls and idling on top
	localparam int CYCLE_LIMIT = 4000000;
	localparam int RANDOM_ITEMS = 330;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  mode;
	logic [2:0]  process_index;
	logic [2:0]  thread_index;
	logic [23:0] duration;
	logic [31:0] directory_base;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic        switched;
	logic [2:0]  sel_process;
	logic [2:0]  sel_thread;
	logic [31:0] directory_out;

	two_level_round_robin_sleep_scheduler DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.process_index(process_index),
		.thread_index(thread_index),
		.duration(duration),
		.directory_base(directory_base),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.switched(switched),
		.sel_process(sel_process),
		.sel_thread(sel_thread),
		.directory_out(directory_out)
	);

	// one row of the directed part; typed rows carry their own answer
	typedef struct {
		req_t req;
		bit   typed;
		res_t answer;
	} sched_row_t;

	int unsigned cycles;
	int unsigned errors;
	res_t        pending_results[$];

	// shadow scheduler state
	logic [PER_W-1:0]  period_ms;
	logic [PIDX_W-1:0] proc_order[NPROC];
	int unsigned       proc_first;
	int unsigned       proc_total;
	logic [DIR_W-1:0]  proc_dir[NPROC];
	logic [TIDX_W-1:0] thr_order[NSLOTS];
	int unsigned       thr_first[NPROC];
	int unsigned       thr_total[NPROC];
	logic [DUR_W-1:0]  nap_left[NSLOTS];
	int unsigned       running_slot;

	initial clk = 1'b0;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// long stretch where neither side idles
	function automatic bit calm_stretch();
		return cycles >= 60000 && cycles < 160000;
	endfunction

	function automatic void shadow_reset();
		period_ms = PERIOD_RESET;
		proc_first = 0;
		proc_total = 1;
		running_slot = 0;
		for (int i = 0; i < NPROC; i++) begin
			proc_order[i] = '0;
			proc_dir[i] = '0;
			thr_first[i] = 0;
			thr_total[i] = 0;
		end
		for (int i = 0; i < NSLOTS; i++) begin
			thr_order[i] = '0;
			nap_left[i] = '0;
		end
		thr_total[0] = 1;
	endfunction

	// steps the shadow state by one request and returns its outcome
	function automatic res_t schedule_step(req_t r);
		res_t o;
		bit found;
		int unsigned p, t, tail, h, nt, slot, d;
		o = '0;
		o.status = ST_OK;
		p = 0;
		t = 0;
		found = 0;
		case (r.mode)
			MODE_TICK: begin
				for (int i = 0; i < NSLOTS && !found; i++) begin
					if (proc_total > 1) begin
						tail = (proc_first + proc_total) % NPROC;
						proc_order[tail] = proc_order[proc_first];
						proc_first = (proc_first + 1) % NPROC;
					end
					p = proc_order[proc_first];
					if (thr_total[p] == 0)
						continue;
					if (thr_total[p] > 1) begin
						h = thr_first[p];
						tail = (h + thr_total[p]) % NTHR;
						thr_order[p*NTHR + tail] = thr_order[p*NTHR + h];
						thr_first[p] = (h + 1) % NTHR;
					end
					t = thr_order[p*NTHR + thr_first[p]];
					if (nap_left[p*NTHR + t] == 0)
						found = 1;
				end
				if (found) begin
					slot = p*NTHR + t;
					o.switched = (slot != running_slot);
					running_slot = slot;
				end else begin
					o.status = ST_NORDY;
				end
				o.sel_process = running_slot / NTHR;
				o.sel_thread = running_slot % NTHR;
				o.directory_out = proc_dir[running_slot / NTHR];
				// every sleeping thread moves one period closer, saturating
				for (int i = 0; i < NSLOTS; i++)
					if (nap_left[i] != 0)
						nap_left[i] = (nap_left[i] > period_ms) ? nap_left[i] - period_ms : '0;
			end
			MODE_NEWPROC: begin
				if (proc_total >= NPROC) begin
					o.status = ST_FULL;
				end else begin
					p = proc_total;
					proc_dir[p] = r.directory_base;
					proc_order[(proc_first + proc_total) % NPROC] = p;
					proc_total++;
					thr_first[p] = 0;
					thr_total[p] = 1;
					thr_order[p*NTHR] = '0;
					nap_left[p*NTHR] = '0;
					o.sel_process = p;
				end
			end
			MODE_NEWTHR: begin
				p = r.process_index;
				if (p >= proc_total) begin
					o.status = ST_BADIX;
				end else if (thr_total[p] >= NTHR) begin
					o.status = ST_FULL;
				end else begin
					nt = thr_total[p];
					thr_order[p*NTHR + (thr_first[p] + nt) % NTHR] = nt;
					thr_total[p] = nt + 1;
					nap_left[p*NTHR + nt] = '0;
					o.sel_process = p;
					o.sel_thread = nt;
				end
			end
			default: begin
				p = r.process_index;
				t = r.thread_index;
				if (p >= proc_total || t >= thr_total[p]) begin
					o.status = ST_BADIX;
				end else begin
					// round down to whole periods, keep the longer sleep
					d = r.duration;
					if (period_ms != 0)
						d = (d / period_ms) * period_ms;
					if (nap_left[p*NTHR + t] < d)
						nap_left[p*NTHR + t] = d;
				end
			end
		endcase
		return o;
	endfunction

	// offers one request, holds it until the transfer, records the outcome
	task automatic offer_request(req_t r, bit typed, res_t answer);
		res_t predicted;
		@(negedge clk);
		while (!calm_stretch() && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		mode <= r.mode;
		process_index <= r.process_index;
		thread_index <= r.thread_index;
		duration <= r.duration;
		directory_base <= r.directory_base;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
		predicted = schedule_step(r);
		pending_results.push_back(typed ? answer : predicted);
	endtask

	// period changes only with nothing in flight
	task automatic set_period(logic [15:0] value);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		period_ms = value;
	endtask

	function automatic req_t random_request();
		req_t r;
		int unsigned pick;
		r.mode = MODE_TICK;
		r.process_index = $urandom_range(7);
		r.thread_index = $urandom_range(7);
		r.directory_base = $urandom();
		r.duration = $urandom();
		pick = $urandom_range(99);
		if (pick < 40) begin
			r.mode = MODE_TICK;
		end else if (pick < 45) begin
			r.mode = MODE_NEWPROC;
		end else if (pick < 58) begin
			r.mode = MODE_NEWTHR;
			if ($urandom_range(9) != 0)
				r.process_index = $urandom_range(proc_total - 1);
		end else begin
			r.mode = MODE_SLEEP;
			// mostly threads that exist, now and then a stray index
			if ($urandom_range(9) != 0) begin
				r.process_index = $urandom_range(proc_total - 1);
				if (thr_total[r.process_index] != 0)
					r.thread_index = $urandom_range(thr_total[r.process_index] - 1);
			end
			case ($urandom_range(4))
				0: r.duration = '0;
				1: r.duration = '1;
				2: r.duration = period_ms * $urandom_range(8) + $urandom_range(3);
				default: r.duration = $urandom();
			endcase
		end
		return r;
	endfunction

	// receiver, with one long hold-off so the block backs up
	initial begin
		int unsigned hold_left;
		bit held;
		res_t want;
		hold_left = 0;
		held = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result transfer with nothing expected");
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (status !== want.status) begin
						$error("status expected %0d actual %0d", want.status, status);
						errors++;
					end
					if (switched !== want.switched) begin
						$error("switched expected %0d actual %0d", want.switched, switched);
						errors++;
					end
					if (sel_process !== want.sel_process) begin
						$error("sel_process expected %0d actual %0d",
							want.sel_process, sel_process);
						errors++;
					end
					if (sel_thread !== want.sel_thread) begin
						$error("sel_thread expected %0d actual %0d",
							want.sel_thread, sel_thread);
						errors++;
					end
					if (directory_out !== want.directory_out) begin
						$error("directory_out expected %h actual %h",
							want.directory_out, directory_out);
						errors++;
					end
				end
			end
			@(negedge clk);
			if (!held && cycles >= 20000) begin
				held = 1;
				hold_left = 4000;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm_stretch() || ($urandom_range(99) >= 36);
			end
		end
	end

	initial begin
		sched_row_t rows[$];
		sched_row_t row;
		res_t none;
		logic [15:0] periods[6];
		int unsigned wait_left;

		cycles = 0;
		errors = 0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		mode = MODE_TICK;
		process_index = '0;
		thread_index = '0;
		duration = '0;
		directory_base = '0;
		shadow_reset();

		// directed rows: mode, process, thread, duration, root, typed, answer
		none = '0;
		row.req = '{MODE_TICK, 3'd0, 3'd0, 24'd0, 32'd0};
		row.typed = 1; row.answer = '{ST_OK, 1'b0, 3'd0, 3'd0, 32'd0}; rows.push_back(row);
		row.req = '{MODE_SLEEP, 3'd5, 3'd0, 24'd100, 32'd0};
		row.typed = 1; row.answer = '{ST_BADIX, 1'b0, 3'd0, 3'd0, 32'd0}; rows.push_back(row);
		row.req = '{MODE_NEWTHR, 3'd1, 3'd0, 24'd0, 32'd0};
		row.typed = 1; row.answer = '{ST_BADIX, 1'b0, 3'd0, 3'd0, 32'd0}; rows.push_back(row);
		row.req = '{MODE_NEWPROC, 3'd7, 3'd7, 24'hFFFFFF, 32'hFFFF_FFFF};
		row.typed = 1; row.answer = '{ST_OK, 1'b0, 3'd1, 3'd0, 32'd0}; rows.push_back(row);
		row.req = '{MODE_NEWPROC, 3'd0, 3'd0, 24'd0, 32'd0};
		row.typed = 1; row.answer = '{ST_OK, 1'b0, 3'd2, 3'd0, 32'd0}; rows.push_back(row);
		row.req = '{MODE_NEWTHR, 3'd0, 3'd0, 24'd0, 32'd0};
		row.typed = 1; row.answer = '{ST_OK, 1'b0, 3'd0, 3'd1, 32'd0}; rows.push_back(row);
		row.req = '{MODE_SLEEP, 3'd0, 3'd7, 24'd0, 32'd0};
		row.typed = 1; row.answer = '{ST_BADIX, 1'b0, 3'd0, 3'd0, 32'd0}; rows.push_back(row);
		row.req = '{MODE_SLEEP, 3'd0, 3'd1, 24'hFFFFFF, 32'd0};
		row.typed = 1; row.answer = none; rows.push_back(row);
		row.typed = 0;
		row.req = '{MODE_TICK, 3'd0, 3'd0, 24'd0, 32'd0}; rows.push_back(row);
		// zero duration is a no-op sleep
		row.req = '{MODE_SLEEP, 3'd1, 3'd0, 24'd0, 32'd0};
		row.typed = 1; row.answer = none; rows.push_back(row);
		row.typed = 0;
		for (int i = 0; i < 5; i++) begin
			row.req = '{MODE_NEWPROC, 3'd0, 3'd0, 24'd0, $urandom()};
			rows.push_back(row);
		end
		// process table now full
		row.req = '{MODE_NEWPROC, 3'd0, 3'd0, 24'd0, 32'h1234_5678};
		row.typed = 1; row.answer = '{ST_FULL, 1'b0, 3'd0, 3'd0, 32'd0}; rows.push_back(row);
		row.typed = 0;
		// shorter than one period rounds to nothing
		row.req = '{MODE_SLEEP, 3'd7, 3'd0, 24'd1, 32'd0}; rows.push_back(row);
		row.req = '{MODE_TICK, 3'd0, 3'd0, 24'd0, 32'd0}; rows.push_back(row);
		for (int i = 0; i < 6; i++) begin
			row.req = '{MODE_NEWTHR, 3'd0, 3'd0, 24'd0, 32'd0};
			rows.push_back(row);
		end
		// thread table of process zero now full
		row.req = '{MODE_NEWTHR, 3'd0, 3'd0, 24'd0, 32'd0};
		row.typed = 1; row.answer = '{ST_FULL, 1'b0, 3'd0, 3'd0, 32'd0}; rows.push_back(row);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_period(PERIOD_RESET);
		foreach (rows[i])
			offer_request(rows[i].req, rows[i].typed, rows[i].answer);

		// period phases: extremes and zero (no wear-off), then two random ones around the reset value
		periods[0] = 16'd1;
		periods[1] = 16'd0;
		periods[2] = 16'hFFFF;
		periods[3] = $urandom_range(65535, 1);
		periods[4] = PERIOD_RESET;
		periods[5] = $urandom_range(255, 2);
		foreach (periods[k]) begin
			set_period(periods[k]);
			for (int i = 0; i < RANDOM_ITEMS; i++)
				offer_request(random_request(), 0, none);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		wait_left = 400;
		while (wait_left != 0) begin
			@(negedge clk);
			wait_left--;
		end
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
